### rtl/iwie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwie_pkg
// Shared types, constants and helpers for the isotope enumerator.
// ----------------------------------------------------------------------------
package iwie_pkg;

    localparam int CHARGE_LIMIT  = 4;
    localparam int ISOTOPE_LIMIT = 7;

    localparam logic [2:0] REG_MIN_CHARGE  = 3'd0;
    localparam logic [2:0] REG_MAX_CHARGE  = 3'd1;
    localparam logic [2:0] REG_MAX_ISOTOPE = 3'd2;
    localparam logic [2:0] REG_CHARGE_PROB = 3'd3;

    localparam logic signed [35:0] PROTON_Q21 = 36'sd2112412;
    localparam logic signed [35:0] MASS_MAX   = 36'sh7FFFFFFFF;
    localparam logic signed [35:0] MASS_MIN   = 36'sh800000000;
    localparam logic signed [27:0] LIK_MAX    = 28'sh7FFFFFF;
    localparam logic signed [27:0] LIK_MIN    = 28'sh8000000;

    typedef struct packed {
        logic       load;
        logic       calc;
        logic       mul;
        logic       rnd;
        logic [2:0] charge;
        logic [2:0] first;
        logic [2:0] last;
        logic [2:0] miso;
        logic       last_of_run;
    } t_dp_cmd;

    typedef struct packed {
        logic reach_le_width;
    } t_dp_status;

    function automatic logic [21:0] f_spacing(input logic [2:0] z);
        logic [21:0] s;
        unique case (z)
            3'd1:    s = 22'd2104188;
            3'd2:    s = 22'd1052094;
            3'd3:    s = 22'd701396;
            3'd4:    s = 22'd526047;
            default: s = 22'd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [35:0] f_sat_mass(input logic signed [39:0] v);
        logic signed [35:0] r;
        if (v > 40'(MASS_MAX)) begin
            r = MASS_MAX;
        end else if (v < 40'(MASS_MIN)) begin
            r = MASS_MIN;
        end else begin
            r = v[35:0];
        end
        return r;
    endfunction

    function automatic logic signed [27:0] f_sat_lik(input logic signed [46:0] v);
        logic signed [27:0] r;
        if (v > 47'(LIK_MAX)) begin
            r = LIK_MAX;
        end else if (v < 47'(LIK_MIN)) begin
            r = LIK_MIN;
        end else begin
            r = v[27:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/iwie_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwie_in_if
// Isolation window request channel.
// ----------------------------------------------------------------------------
interface iwie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] isolation_center;
    logic [25:0] isolation_width;

    modport source(output valid, output isolation_center, output isolation_width,
                   input ready);
    modport sink(input valid, input isolation_center, input isolation_width,
                 output ready);
endinterface
`default_nettype wire

### rtl/iwie_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwie_out_if
// Candidate result channel.
// ----------------------------------------------------------------------------
interface iwie_out_if;
    logic               valid;
    logic               ready;
    logic signed [35:0] min_mono_mass;
    logic signed [35:0] max_mono_mass;
    logic [2:0]         charge;
    logic [2:0]         first_isotope;
    logic [2:0]         last_isotope;
    logic signed [27:0] likelihood;
    logic               last_of_run;

    modport source(output valid, output min_mono_mass, output max_mono_mass,
                   output charge, output first_isotope, output last_isotope,
                   output likelihood, output last_of_run, input ready);
    modport sink(input valid, input min_mono_mass, input max_mono_mass,
                 input charge, input first_isotope, input last_isotope,
                 input likelihood, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/iwie_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwie_dp
// Window bounds, shift limits, mass and likelihood arithmetic.
// ----------------------------------------------------------------------------
module iwie_dp (
    input  wire logic                 i_clk,
    input  wire iwie_pkg::t_dp_cmd    i_cmd,
    output iwie_pkg::t_dp_status      o_status,
    input  wire logic [31:0]          i_center,
    input  wire logic [25:0]          i_width,
    input  wire logic [63:0]          i_probs,
    output logic signed [35:0]        o_min_mono_mass,
    output logic signed [35:0]        o_max_mono_mass,
    output logic [2:0]                o_charge,
    output logic [2:0]                o_first_isotope,
    output logic [2:0]                o_last_isotope,
    output logic signed [27:0]        o_likelihood,
    output logic                      o_last_of_run
);
    import iwie_pkg::*;

    logic signed [35:0] r_left, r_right;
    logic [26:0]        r_w;
    logic signed [35:0] r_sl, r_sr, r_inner;
    logic signed [39:0] r_mn, r_mx;
    logic signed [46:0] r_lik;
    logic [21:0]        s;
    logic [3:0]         k_span, k_reach;
    logic [24:0]        inner, span, reach;
    logic signed [35:0] n_sl, n_sr;
    logic signed [35:0] a_mn, a_mx, diff;
    logic [15:0]        prob;
    logic signed [39:0] rnd_mn, rnd_mx;
    logic signed [46:0] rnd_lik;

    always_comb begin
        s       = f_spacing(i_cmd.charge);
        k_span  = 4'(i_cmd.last) - 4'(i_cmd.first);
        k_reach = k_span + 4'd1;
        inner   = 25'(i_cmd.first) * 25'(s);
        span    = 25'(k_span) * 25'(s);
        reach   = 25'(k_reach) * 25'(s);
        o_status.reach_le_width = (27'(reach) <= r_w);
        if (i_cmd.first != 3'd0 && r_w >= 27'(reach)) begin
            n_sr = r_left + 36'(s);
        end else begin
            n_sr = r_right - 36'(span);
        end
        if (i_cmd.last != i_cmd.miso && r_w > 27'(reach)) begin
            n_sl = r_right - 36'(s) - 36'(span);
        end else begin
            n_sl = r_left;
        end
        a_mn = r_sl - r_inner - PROTON_Q21;
        a_mx = r_sr - r_inner - PROTON_Q21;
        diff = r_sr - r_sl;
        unique case (i_cmd.charge)
            3'd1:    prob = i_probs[15:0];
            3'd2:    prob = i_probs[31:16];
            3'd3:    prob = i_probs[47:32];
            3'd4:    prob = i_probs[63:48];
            default: prob = 16'd0;
        endcase
        rnd_mn  = (r_mn + 40'sd1) >>> 1;
        rnd_mx  = (r_mx + 40'sd1) >>> 1;
        rnd_lik = (r_lik + 47'sd65536) >>> 17;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= $signed({3'b0, i_center, 1'b0}) - $signed({10'b0, i_width});
            r_right <= $signed({3'b0, i_center, 1'b0}) + $signed({10'b0, i_width});
            r_w     <= {i_width, 1'b0};
        end
        if (i_cmd.calc) begin
            r_sl    <= n_sl;
            r_sr    <= n_sr;
            r_inner <= $signed({11'b0, inner});
        end
        if (i_cmd.mul) begin
            r_mn  <= $signed({1'b0, i_cmd.charge}) * a_mn;
            r_mx  <= $signed({1'b0, i_cmd.charge}) * a_mx;
            r_lik <= $signed(diff[29:0]) * $signed({1'b0, prob});
        end
        if (i_cmd.rnd) begin
            o_min_mono_mass <= f_sat_mass(rnd_mn);
            o_max_mono_mass <= f_sat_mass(rnd_mx);
            o_likelihood    <= f_sat_lik(rnd_lik);
            o_charge        <= i_cmd.charge;
            o_first_isotope <= i_cmd.first;
            o_last_isotope  <= i_cmd.last;
            o_last_of_run   <= i_cmd.last_of_run;
        end
    end

endmodule
`default_nettype wire

### rtl/iwie_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwie_ctrl
// Sequencer over charge and isotope window positions.
// ----------------------------------------------------------------------------
module iwie_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [2:0]          i_min_charge,
    input  wire logic [2:0]          i_max_charge,
    input  wire logic [2:0]          i_max_isotope,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output iwie_pkg::t_dp_cmd        o_cmd,
    input  wire iwie_pkg::t_dp_status i_status
);
    import iwie_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_MUL  = 5'b00100,
        S_RND  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_z, r_f, r_l, r_nz, r_nf, r_nl;
    logic       r_last;
    logic [2:0] lo, hi;
    logic [3:0] step_f, step_l;
    logic [2:0] n_nz, n_nf, n_nl;
    logic       n_last;
    logic       in_acc;

    always_comb begin
        lo = (i_min_charge == 3'd0) ? 3'd1 : i_min_charge;
        hi = (i_max_charge > 3'(CHARGE_LIMIT)) ? 3'(CHARGE_LIMIT) : i_max_charge;
        in_acc = i_in_valid && o_in_ready;
        if (r_l < i_max_isotope && i_status.reach_le_width) begin
            step_f = {1'b0, r_f};
            step_l = {1'b0, r_l} + 4'd1;
        end else begin
            step_f = {1'b0, r_f} + 4'd1;
            step_l = (step_f > {1'b0, r_l}) ? {1'b0, r_l} + 4'd1 : {1'b0, r_l};
        end
        if (step_f > {1'b0, i_max_isotope}) begin
            n_nz   = r_z + 3'd1;
            n_nf   = 3'd0;
            n_nl   = 3'd0;
            n_last = (r_z == hi);
        end else begin
            n_nz   = r_z;
            n_nf   = step_f[2:0];
            n_nl   = step_l[2:0];
            n_last = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && lo <= hi) n_state = S_CALC;
            S_CALC: n_state = S_MUL;
            S_MUL:  n_state = S_RND;
            S_RND:  n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_ready) n_state = r_last ? S_IDLE : S_CALC;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_z <= lo;
            r_f <= 3'd0;
            r_l <= 3'd0;
        end
        if (r_state == S_CALC) begin
            r_nz   <= n_nz;
            r_nf   <= n_nf;
            r_nl   <= n_nl;
            r_last <= n_last;
        end
        if (r_state == S_EMIT && i_out_ready) begin
            r_z <= r_nz;
            r_f <= r_nf;
            r_l <= r_nl;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        o_cmd.load        = in_acc;
        o_cmd.calc        = (r_state == S_CALC);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.rnd         = (r_state == S_RND);
        o_cmd.charge      = r_z;
        o_cmd.first       = r_f;
        o_cmd.last        = r_l;
        o_cmd.miso        = i_max_isotope;
        o_cmd.last_of_run = r_last;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request and result both open");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_f <= r_l))
        else $error("isotope window inverted");

    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_out_ready && !r_last) |=> (r_state == S_CALC))
        else $error("walk stopped early");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_out_ready && r_last) |=> o_in_ready)
        else $error("walk did not finish");

endmodule
`default_nettype wire

### rtl/isolation_window_isotope_enumerator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isolation_window_isotope_enumerator_top
// Enumerates precursor candidates for one isolation window.
// ----------------------------------------------------------------------------
// One request in, one candidate beat per window position out, for every
// charge from min_charge (at least 1) to max_charge (at most 4) and a walk of
// isotope windows over 0..max_isotope; last_of_run marks the final beat. Each
// candidate passes the sequencer states bounds, multiply, round and emit, the
// emit state holding while the output stalls, so a request yields up to 60
// candidates and no new request is taken before its run ends; a new request
// is taken in the cycle after the last beat is taken.
// An empty charge range takes the request and emits nothing.
module isolation_window_isotope_enumerator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    iwie_in_if.sink          i_in,
    iwie_out_if.source       o_out
);
    import iwie_pkg::*;

    logic [2:0]  r_min_charge, r_max_charge, r_max_isotope;
    logic [63:0] r_probs;
    t_dp_cmd     cmd;
    t_dp_status  status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_charge  <= 3'd1;
            r_max_charge  <= 3'd4;
            r_max_isotope <= 3'd5;
            r_probs       <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_CHARGE:  r_min_charge  <= i_cfg_data[2:0];
                REG_MAX_CHARGE:  r_max_charge  <= i_cfg_data[2:0];
                REG_MAX_ISOTOPE: r_max_isotope <= i_cfg_data[2:0];
                REG_CHARGE_PROB: r_probs       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    iwie_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_charge  (r_min_charge),
        .i_max_charge  (r_max_charge),
        .i_max_isotope (r_max_isotope),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    iwie_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_center        (i_in.isolation_center),
        .i_width         (i_in.isolation_width),
        .i_probs         (r_probs),
        .o_min_mono_mass (o_out.min_mono_mass),
        .o_max_mono_mass (o_out.max_mono_mass),
        .o_charge        (o_out.charge),
        .o_first_isotope (o_out.first_isotope),
        .o_last_isotope  (o_out.last_isotope),
        .o_likelihood    (o_out.likelihood),
        .o_last_of_run   (o_out.last_of_run)
    );

endmodule
`default_nettype wire

### dv/iwie_tb_pkg.sv
// ----------------------------------------------------------------------------
// iwie_tb_pkg
// Candidate record and the window enumeration predictor for the testbench.
// ----------------------------------------------------------------------------
package iwie_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    import iwie_pkg::*;

    typedef struct packed {
        logic signed [35:0] min_mono_mass;
        logic signed [35:0] max_mono_mass;
        logic [2:0]         charge;
        logic [2:0]         first_isotope;
        logic [2:0]         last_isotope;
        logic signed [27:0] likelihood;
        logic               last_of_run;
    } t_candidate;

    typedef struct {
        logic [2:0]  min_charge;
        logic [2:0]  max_charge;
        logic [2:0]  max_isotope;
        logic [63:0] charge_prob;
    } t_enum_cfg;

    localparam longint SPACING_Q21 [5] = '{0, 2104188, 1052094, 701396, 526047};
    localparam longint PROTON = 2112412;

    function automatic longint half_up_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void enumerate_windows(input t_enum_cfg c, input logic [31:0] ctr,
                                              input logic [25:0] wid,
                                              ref t_candidate q[$]);
        longint center, width, half, right, left, lo, hi, miso, z, s, prob;
        longint first, last, inner, span, reach, sr, sl, mn, mx, lik;
        t_candidate cand;
        int n;
        center = longint'(ctr) * 2;
        width = longint'(wid) * 2;
        half = width / 2;
        right = center + half;
        left = center - half;
        lo = (c.min_charge < 1) ? 1 : c.min_charge;
        hi = (c.max_charge > CHARGE_LIMIT) ? CHARGE_LIMIT : c.max_charge;
        miso = (c.max_isotope > ISOTOPE_LIMIT) ? ISOTOPE_LIMIT : c.max_isotope;
        n = 0;
        for (z = lo; z <= hi; z++) begin
            s = SPACING_Q21[z];
            prob = (c.charge_prob >> (16 * (z - 1))) & 64'hFFFF;
            first = 0;
            last = 0;
            while (first <= miso) begin
                inner = first * s;
                span = (last - first) * s;
                reach = (last - first + 1) * s;
                sr = (first != 0 && width >= reach) ? left + s : right - span;
                sl = (last != miso && width > reach) ? right - s - span : left;
                mn = (sl - inner - PROTON) * z;
                mx = (sr - inner - PROTON) * z;
                lik = half_up_shift((sr - sl) * prob, 17);
                cand.min_mono_mass = 36'(clamp(half_up_shift(mn, 1), -(64'sd1 <<< 35),
                                               (64'sd1 <<< 35) - 1));
                cand.max_mono_mass = 36'(clamp(half_up_shift(mx, 1), -(64'sd1 <<< 35),
                                               (64'sd1 <<< 35) - 1));
                cand.charge = 3'(z);
                cand.first_isotope = 3'(first);
                cand.last_isotope = 3'(last);
                cand.likelihood = 28'(clamp(lik, -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1));
                cand.last_of_run = 1'b0;
                q.push_back(cand);
                n++;
                if (last < miso && reach <= width) begin
                    last++;
                end else begin
                    first++;
                    if (first > last) last++;
                end
            end
        end
        if (n > 0) q[q.size() - 1].last_of_run = 1'b1;
    endfunction
endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives isolation windows through the enumerator under several register
// settings, with random gaps and stalls, and checks every candidate beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iwie_pkg::*;
    import iwie_tb_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd5;

    typedef struct packed {
        logic [31:0] center;
        logic [25:0] width;
    } t_window;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    iwie_in_if  win_if ();
    iwie_out_if cand_if ();

    isolation_window_isotope_enumerator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (win_if),
        .o_out      (cand_if)
    );

    t_window    pending_windows[$];
    t_candidate expected_cands[$];
    t_enum_cfg  cfg;
    int         mismatches = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_off = 0;
    bit         hold_start = 0;
    longint     cycle_count = 0;
    bit         stim_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_if.valid <= 1'b0;
        end else if (win_if.valid && !win_if.ready) begin
        end else if (send_gap > 0) begin
            win_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_windows.size() > 0) begin
            t_window w;
            w = pending_windows.pop_front();
            enumerate_windows(cfg, w.center, w.width, expected_cands);
            win_if.valid <= 1'b1;
            win_if.isolation_center <= w.center;
            win_if.isolation_width <= w.width;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        end else begin
            win_if.valid <= 1'b0;
        end
    end

    // receive hold-off
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_off <= 600;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_if.ready <= 1'b0;
        end else begin
            if (cand_if.valid && cand_if.ready) begin
                t_candidate got, exp_c;
                got = '{cand_if.min_mono_mass, cand_if.max_mono_mass, cand_if.charge,
                        cand_if.first_isotope, cand_if.last_isotope,
                        cand_if.likelihood, cand_if.last_of_run};
                if (expected_cands.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", got);
                end else begin
                    exp_c = expected_cands.pop_front();
                    if (got !== exp_c) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat mismatch\n  exp %p\n  got %p", exp_c, got);
                    end
                end
            end
            if (hold_off > 0) begin
                cand_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                cand_if.ready <= 1'b0;
            end else begin
                cand_if.ready <= 1'b1;
                if (cand_if.valid)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MIN_CHARGE:  cfg.min_charge = data[2:0];
            REG_MAX_CHARGE:  cfg.max_charge = data[2:0];
            REG_MAX_ISOTOPE: cfg.max_isotope = data[2:0];
            REG_CHARGE_PROB: cfg.charge_prob = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_windows.size() > 0 || win_if.valid || expected_cands.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_window rand_window();
        t_window w;
        w.center = {$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h7FFFFFF)};
        case ($urandom_range(0, 3))
            0:       w.width = 26'($urandom);
            1:       w.width = 26'($urandom_range(0, 26'h3FFFFF));
            default: w.width = 26'($urandom_range(0, 26'h0FFFFF));
        endcase
        return w;
    endfunction

    task automatic directed_set();
        pending_windows.push_back('{32'd0, 26'd0});
        pending_windows.push_back('{32'hFFFFFFFF, 26'h3FFFFFF});
        pending_windows.push_back('{32'd0, 26'h3FFFFFF});
        pending_windows.push_back('{32'hFFFFFFFF, 26'd0});
        pending_windows.push_back('{32'h1F400000, 26'd1048576});
        pending_windows.push_back('{32'h1F400000, 26'd2104188});
        pending_windows.push_back('{32'h1F400000, 26'd1052094});
        pending_windows.push_back('{32'h1F400000, 26'd526047});
        pending_windows.push_back('{32'h1F400000, 26'd526048});
        pending_windows.push_back('{32'h00000001, 26'd1});
        pending_windows.push_back('{32'h55555555, 26'h2AAAAAA});
        pending_windows.push_back('{32'hAAAAAAAA, 26'h1555555});
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) pending_windows.push_back(rand_window());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MIN_CHARGE;
        i_cfg_data = '0;
        win_if.valid = 1'b0;
        win_if.isolation_center = '0;
        win_if.isolation_width = '0;
        cand_if.ready = 1'b0;
        cfg = '{3'd1, 3'd4, 3'd5, 64'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_set();
        drain();

        write_reg(REG_CHARGE_PROB, 64'hFFFF_0000_8000_FFFF);
        write_reg(REG_MAX_ISOTOPE, 64'd7);
        directed_set();
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        random_phase(40);
        drain();

        write_reg(REG_MIN_CHARGE, 64'd0);
        write_reg(REG_MAX_CHARGE, 64'd7);
        write_reg(REG_MAX_ISOTOPE, 64'd0);
        write_reg(REG_SPARE, 64'hFFFF);
        random_phase(60);
        drain();

        write_reg(REG_MIN_CHARGE, 64'd3);
        write_reg(REG_MAX_CHARGE, 64'd2);
        random_phase(20);
        drain();

        write_reg(REG_MIN_CHARGE, 64'd4);
        write_reg(REG_MAX_CHARGE, 64'd4);
        write_reg(REG_MAX_ISOTOPE, 64'd3);
        write_reg(REG_CHARGE_PROB, {$urandom, $urandom});
        random_phase(80);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_reg(REG_MIN_CHARGE, 64'($urandom_range(0, 7)));
            write_reg(REG_MAX_CHARGE, 64'($urandom_range(1, 7)));
            write_reg(REG_MAX_ISOTOPE, 64'($urandom_range(0, 7)));
            write_reg(REG_CHARGE_PROB, {$urandom, $urandom});
            random_phase(50);
            drain();
        end

        if (mismatches == 0 && expected_cands.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
